/* design/greedy_independent_set_partition_defines.svh */
// assertion helpers shared by the partition block
`ifndef GREEDY_INDEPENDENT_SET_PARTITION_DEFINES_SVH
`define GREEDY_INDEPENDENT_SET_PARTITION_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define GISP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gisp assertion failed");

// consequence must hold in the cycle after the antecedent
`define GISP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gisp assertion failed");

`endif

/* design/gisp_pkg.sv */
`timescale 1ns / 1ps
package gisp_pkg;

   // field widths of the words
   localparam int VID_W   = 6;
   localparam int MASK_W  = 64;
   localparam int TOTAL_W = 7;

   // graph size and derived widths
   localparam int NUM_VERTICES = 64;
   localparam int IDX_W = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int CNT_W = $clog2(NUM_VERTICES + 1);
   localparam logic [MASK_W-1:0] VERT_MASK =
      (NUM_VERTICES >= MASK_W) ? {MASK_W{1'b1}} :
      ((MASK_W'(1) << NUM_VERTICES) - MASK_W'(1));

   typedef struct packed {
      logic              start_graph;
      logic [VID_W-1:0]  vertex_id;
      logic [MASK_W-1:0] neighbour_mask;
   } req_word_type;

   typedef struct packed {
      logic [VID_W-1:0]   set_index;
      logic               opened_new;
      logic               duplicate;
      logic [TOTAL_W-1:0] set_total;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
      logic join_set;
      logic open_set;
      logic dup;
   } gisp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dup;
      logic count_zero;
      logic count_full;
      logic fits;
      logic last;
   } gisp_stat_type;

endpackage

/* design/gisp_datapath.sv */
`timescale 1ns / 1ps
`include "greedy_independent_set_partition_defines.svh"
module gisp_datapath
   import gisp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  gisp_cmd_type  cmd,
   output gisp_stat_type stat,
   output rsp_word_type  rsp_word
);

   // set membership memory, entries below the set count are live
   logic [MASK_W-1:0] set_mem [NUM_VERTICES];
   logic [MASK_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;

   logic [VID_W-1:0]  vid_ff;
   logic [MASK_W-1:0] nb_ff;
   logic [IDX_W-1:0]  j_ff;
   logic [IDX_W-1:0]  j_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [MASK_W-1:0] placed_ff;
   logic [MASK_W-1:0] placed_in;
   rsp_word_type      rsp_ff;
   rsp_word_type      rsp_in;
   logic [MASK_W-1:0] vbit;

   assign vbit = MASK_W'(1) << vid_ff;

   // scan index and read address
   assign rd_addr = cmd.advance ? (j_ff + IDX_W'(1)) : j_ff;

   always_comb begin
      j_in = j_ff;
      if (cmd.load) begin
         j_in = '0;
      end else if (cmd.advance) begin
         j_in = j_ff + IDX_W'(1);
      end
   end

   // set count and placed mask
   always_comb begin
      count_in  = count_ff;
      placed_in = placed_ff;
      if (cmd.load && req_word.start_graph) begin
         count_in  = '0;
         placed_in = '0;
      end
      if (cmd.open_set) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.open_set || cmd.join_set) begin
         placed_in = placed_ff | vbit;
      end
   end

   // result word
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.dup) begin
         rsp_in.set_index  = '0;
         rsp_in.opened_new = 1'b0;
         rsp_in.duplicate  = 1'b1;
         rsp_in.set_total  = TOTAL_W'(count_ff);
      end else if (cmd.open_set) begin
         rsp_in.set_index  = VID_W'(count_ff);
         rsp_in.opened_new = 1'b1;
         rsp_in.duplicate  = 1'b0;
         rsp_in.set_total  = TOTAL_W'(count_ff + CNT_W'(1));
      end else if (cmd.join_set) begin
         rsp_in.set_index  = VID_W'(j_ff);
         rsp_in.opened_new = 1'b0;
         rsp_in.duplicate  = 1'b0;
         rsp_in.set_total  = TOTAL_W'(count_ff);
      end
   end

   // status toward the controller
   always_comb begin
      stat.is_dup     = ({1'b0, vid_ff} >= (VID_W+1)'(NUM_VERTICES)) || placed_ff[vid_ff];
      stat.count_zero = (count_ff == '0);
      stat.count_full = (count_ff == CNT_W'(NUM_VERTICES));
      stat.fits       = ((rd_data_ff & nb_ff) == '0);
      stat.last       = ((CNT_W'(j_ff) + CNT_W'(1)) == count_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         placed_ff <= '0;
      end else begin
         count_ff  <= count_in;
         placed_ff <= placed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vid_ff <= req_word.vertex_id;
         nb_ff  <= req_word.neighbour_mask & VERT_MASK;
      end
      j_ff   <= j_in;
      rsp_ff <= rsp_in;
   end

   // set memory, at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.join_set) begin
         set_mem[j_ff] <= rd_data_ff | vbit;
      end else if (cmd.open_set) begin
         set_mem[count_ff[IDX_W-1:0]] <= vbit;
      end
      rd_data_ff <= set_mem[rd_addr];
   end

   assign rsp_word = rsp_ff;

   `GISP_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(NUM_VERTICES))
   `GISP_ASSERT_NEXT(a_open_count, cmd.open_set, count_ff == $past(count_ff) + CNT_W'(1))
   `GISP_ASSERT_NEXT(a_place_mark, cmd.join_set || cmd.open_set, placed_ff[$past(vid_ff)])

endmodule

/* design/gisp_ctrl.sv */
`timescale 1ns / 1ps
`include "greedy_independent_set_partition_defines.svh"
module gisp_ctrl
   import gisp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  gisp_stat_type stat,
   output gisp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      commit;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencing of one word
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.is_dup && !stat.count_zero) begin
               state_in = ST_SCAN;
            end else if (out_free) begin
               cmd.dup      = stat.is_dup;
               cmd.open_set = !stat.is_dup;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.fits) begin
               if (out_free) begin
                  cmd.join_set = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (stat.last) begin
               if (out_free) begin
                  cmd.dup      = stat.count_full;
                  cmd.open_set = !stat.count_full;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   assign commit = cmd.join_set || cmd.open_set || cmd.dup;

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `GISP_ASSERT_NEXT(a_accept_check, req_valid && !req_stall, state_ff == ST_CHECK)
   `GISP_ASSERT_NOW(a_one_commit, 1'b1, $onehot0({cmd.join_set, cmd.open_set, cmd.dup}))

endmodule

/* design/greedy_independent_set_partition.sv */
// sequence: a duplicate vertex or the first set of a graph is settled in the check state; else the
//   sets are scanned in order until the vertex joins set j, or all are tested and a new one opens
// throughput: one word at a time; one existing set is tested per cycle through the single
//   registered read port of the set memory, the next word is taken once the result is registered
// reset: clears set count, placed mask, result valid and sequencer state; the set memory is not
//   cleared, entries at or above the set count are never used
`timescale 1ns / 1ps
module greedy_independent_set_partition
   import gisp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   gisp_cmd_type  cmd;
   gisp_stat_type stat;

   // sequencer
   gisp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // set memory, counters and result register
   gisp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
